@@ rtl/itoa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and helpers of the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_W     = 64;
  localparam int NUM_DIGITS  = 20;
  localparam int DIGIT_IDX_W = 5;
  localparam int CONV_BITS   = 4;
  localparam int CONV_STEPS  = VALUE_W / CONV_BITS;
  localparam int CONV_CNT_W  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_SHEX = 2'd2;
  localparam logic [1:0] OP_UHEX = 2'd3;

  localparam logic [1:0] SC_SHORT = 2'd0;
  localparam logic [1:0] SC_WORD  = 2'd1;
  localparam logic [1:0] SC_LONG  = 2'd2;

  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_X        = 8'h78;
  localparam logic [7:0] CH_HEX_BASE = 8'h61 - 8'd10;

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  typedef struct packed {
    logic               neg;
    logic               hex;
    logic [VALUE_W-1:0] mag;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_SIZE,
    BK_SIGN,
    BK_PFX0,
    BK_PFXX,
    BK_DIGIT
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib <= 4'd9) begin
      c = CH_ZERO + {4'b0, nib};
    end else begin
      c = CH_HEX_BASE + {4'b0, nib};
    end
    return c;
  endfunction

endpackage

@@ rtl/integer_to_ascii_converter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_converter_core
// Converts one integer request into its decimal or hex ASCII text.
//
// Request channel (req_valid/req_ready): op, size_class, value. The front
// decodes sign and magnitude and places the request in a two-entry queue,
// so up to two requests are taken while the back is busy.
// Character channel (chr_valid/chr_ready): one character per transfer,
// last set on the final character of a request.
// When idle, the back takes a queued request in the cycle after it arrives.
// Decimal requests pass through the shift-add-3 converter (four magnitude
// bits per cycle) and a step that locates the leading digit, then emit 1
// to 20 characters; hex requests skip the converter. The back takes a new
// request only after it has emitted the last character of the one before.
// A stalled receiver holds the character register; the back waits and the
// queue absorbs new requests until it fills.
// Reset empties the queue and output register and idles the back.
// ----------------------------------------------------------------------------
module integer_to_ascii_converter_core import itoa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         op,
  input  logic [1:0]         size_class,
  input  logic [VALUE_W-1:0] value,
  output logic               chr_valid,
  input  logic               chr_ready,
  output logic [7:0]         character,
  output logic               last
);

  logic push_valid;
  logic push_ready;
  req_t push_req;
  logic pop_valid;
  logic pop_ready;
  req_t pop_req;

  itoa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .op         (op),
    .size_class (size_class),
    .value      (value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  itoa_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  itoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_req   (pop_req),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .character (character),
    .last      (last)
  );

endmodule

@@ rtl/itoa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_front
// Accepts requests, decodes the operation and size class, and forms the
// sign flag and the magnitude handed to the queue.
// ----------------------------------------------------------------------------
module itoa_front import itoa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         op,
  input  logic [1:0]         size_class,
  input  logic [VALUE_W-1:0] value,
  output logic               push_valid,
  input  logic               push_ready,
  output req_t               push_req
);

  logic        is_signed;
  logic        is_hex;
  logic        is_long;
  logic        is_short;
  logic        neg;
  logic [31:0] low_word;
  logic [31:0] low_mag;
  logic [VALUE_W-1:0] full_mag;
  logic [VALUE_W-1:0] mag;

  assign is_signed = (op == OP_SDEC) || (op == OP_SHEX);
  assign is_hex    = (op == OP_SHEX) || (op == OP_UHEX);
  assign is_long   = size_class[1];
  assign is_short  = (size_class == SC_SHORT);
  assign low_word  = value[31:0];

  assign neg      = is_signed && (is_long ? value[VALUE_W-1] : low_word[31]);
  assign low_mag  = neg ? (~low_word + 32'd1) : low_word;
  assign full_mag = neg ? (~value + 64'd1) : value;

  always_comb begin
    if (is_long) begin
      mag = full_mag;
    end else if (is_short && is_hex) begin
      mag = {48'b0, low_mag[15:0]};
    end else begin
      mag = {32'b0, low_mag};
    end
  end

  assign push_req.neg = neg;
  assign push_req.hex = is_hex;
  assign push_req.mag = mag;

  assign push_valid = req_valid;
  assign req_ready  = push_ready;

  property p_long_sign;
    @(posedge clk) disable iff (rst)
      (req_valid && is_long && !value[VALUE_W-1]) |-> !push_req.neg;
  endproperty
  a_long_sign: assert property (p_long_sign) else $error("positive long marked negative");

  property p_narrow_mag;
    @(posedge clk) disable iff (rst)
      (req_valid && !is_long) |-> (push_req.mag[VALUE_W-1:32] == 32'b0);
  endproperty
  a_narrow_mag: assert property (p_narrow_mag) else $error("narrow magnitude too wide");

  property p_unsigned_pass;
    @(posedge clk) disable iff (rst)
      (req_valid && is_long && !is_signed) |-> (push_req.mag == value);
  endproperty
  a_unsigned_pass: assert property (p_unsigned_pass) else $error("unsigned long altered");

endmodule

@@ rtl/itoa_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_fifo
// Two-entry queue of decoded requests between the front and the back.
// ----------------------------------------------------------------------------
module itoa_fifo import itoa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_req,
  output logic pop_valid,
  input  logic pop_ready,
  output req_t pop_req
);

  req_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;
  logic                   pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_req    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  property p_count_bound;
    @(posedge clk) disable iff (rst)
      count <= QUEUE_CNT_W'(QUEUE_DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("queue overfilled");

  property p_ptr_gap;
    @(posedge clk) disable iff (rst)
      (count == QUEUE_CNT_W'(QUEUE_DEPTH)) || (count == '0) |-> (wr_ptr == rd_ptr);
  endproperty
  a_ptr_gap: assert property (p_ptr_gap) else $error("queue pointers out of step");

  property p_pop_lower;
    @(posedge clk) disable iff (rst)
      (pop && !push) |=> (count == $past(count) - 1'b1);
  endproperty
  a_pop_lower: assert property (p_pop_lower) else $error("queue count missed a pop");

endmodule

@@ rtl/itoa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_back
// Converts the magnitude to digits (shift-add-3, four bits per cycle for
// decimal, direct nibbles for hex), finds the leading digit, and emits the
// sign, prefix and digits via an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module itoa_back import itoa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  req_t       pop_req,
  output logic       chr_valid,
  input  logic       chr_ready,
  output logic [7:0] character,
  output logic       last
);

  back_state_t            state;
  back_state_t            state_next;
  logic                   job_neg;
  logic                   job_hex;
  logic [VALUE_W-1:0]     shreg;
  digits_t                bcd;
  logic [CONV_CNT_W-1:0]  cnt;
  logic [DIGIT_IDX_W-1:0] idx;
  logic                   out_load;
  logic                   pop;
  logic                   emit;
  logic                   emit_last;
  logic [7:0]             emit_char;

  function automatic digits_t dabble(input digits_t b_in, input logic [CONV_BITS-1:0] bits);
    digits_t                b;
    logic [NUM_DIGITS*4:0]  tmp;
    b = b_in;
    for (int s = 0; s < CONV_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (b[d] >= 4'd5) begin
          b[d] = b[d] + 4'd3;
        end
      end
      tmp = {b, bits[CONV_BITS-1-s]};
      b   = tmp[NUM_DIGITS*4-1:0];
    end
    return b;
  endfunction

  function automatic logic [DIGIT_IDX_W-1:0] msd(input digits_t b);
    logic [DIGIT_IDX_W-1:0] m;
    m = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (b[d] != 4'd0) begin
        m = DIGIT_IDX_W'(d);
      end
    end
    return m;
  endfunction

  assign out_load = !chr_valid || chr_ready;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          state_next = pop_req.hex ? BK_SIZE : BK_CONV;
        end
      end
      BK_CONV: begin
        if (cnt == CONV_CNT_W'(CONV_STEPS - 1)) begin
          state_next = BK_SIZE;
        end
      end
      BK_SIZE: begin
        state_next = job_neg ? BK_SIGN : (job_hex ? BK_PFX0 : BK_DIGIT);
      end
      BK_SIGN: begin
        if (out_load) begin
          state_next = job_hex ? BK_PFX0 : BK_DIGIT;
        end
      end
      BK_PFX0: begin
        if (out_load) begin
          state_next = BK_PFXX;
        end
      end
      BK_PFXX: begin
        if (out_load) begin
          state_next = BK_DIGIT;
        end
      end
      BK_DIGIT: begin
        if (out_load && idx == '0) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == BK_IDLE) && pop_valid;
    emit      = out_load && (state inside {BK_SIGN, BK_PFX0, BK_PFXX, BK_DIGIT});
    emit_last = (state == BK_DIGIT) && (idx == '0);
    case (state)
      BK_SIGN:  emit_char = CH_MINUS;
      BK_PFX0:  emit_char = CH_ZERO;
      BK_PFXX:  emit_char = CH_X;
      BK_DIGIT: emit_char = digit_char(bcd[idx]);
      default:  emit_char = CH_ZERO;
    endcase
  end

  assign pop_ready = (state == BK_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_neg <= pop_req.neg;
      job_hex <= pop_req.hex;
      shreg   <= pop_req.mag;
      bcd     <= pop_req.hex ? digits_t'({{(NUM_DIGITS*4-VALUE_W){1'b0}}, pop_req.mag})
                             : '0;
      cnt     <= '0;
    end else if (state == BK_CONV) begin
      shreg <= shreg << CONV_BITS;
      bcd   <= dabble(bcd, shreg[VALUE_W-1 -: CONV_BITS]);
      cnt   <= cnt + 1'b1;
    end
    if (state == BK_SIZE) begin
      idx <= msd(bcd);
    end else if (emit && state == BK_DIGIT) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (out_load) begin
      chr_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character <= emit_char;
      last      <= emit_last;
    end
  end

  property p_last_ends;
    @(posedge clk) disable iff (rst)
      (emit && emit_last) |=> (state == BK_IDLE);
  endproperty
  a_last_ends: assert property (p_last_ends) else $error("conversion ran past last character");

  property p_conv_dec;
    @(posedge clk) disable iff (rst)
      (state == BK_CONV) |-> !job_hex;
  endproperty
  a_conv_dec: assert property (p_conv_dec) else $error("hex request in decimal conversion");

  property p_idx_range;
    @(posedge clk) disable iff (rst)
      (state == BK_DIGIT) |-> (idx < DIGIT_IDX_W'(NUM_DIGITS));
  endproperty
  a_idx_range: assert property (p_idx_range) else $error("digit index out of range");

endmodule
